@@ sv/dqap_pkg.sv @@
// Shared types for the dotted-quad address parser.
`timescale 1ns / 1ps
`default_nettype none

package dqap_pkg;

  // Digit value of a character that is not a hex digit.
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // Classification of one character, produced by the front and used by the back.
  typedef struct packed {
    logic       is_nul;
    logic       is_ws;
    logic       is_star;
    logic       is_dot;
    logic       is_sign;
    logic       is_minus;
    logic       is_x;
    logic [4:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

@@ sv/dqap_char_if.sv @@
// Character channel: one string character per item.
`timescale 1ns / 1ps
`default_nettype none

interface dqap_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

@@ sv/dqap_result_if.sv @@
// Result channel: validity flag and parsed address per item.
`timescale 1ns / 1ps
`default_nettype none

interface dqap_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink   (input valid, input ok, input address, output ready);
endinterface

`default_nettype wire

@@ sv/dqap_front.sv @@
// Front stage: accepts characters and registers their classification.
`timescale 1ns / 1ps
`default_nettype none

module dqap_front
  import dqap_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  dqap_char_if.sink    in_ch,
  output logic         push_valid,
  output char_class_t  push_class,
  input  logic         push_ready
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  logic        valid_r;
  logic        valid_nxt;
  char_class_t class_r;
  char_class_t class_nxt;
  logic        accept;
  logic [7:0]  c;
  logic [7:0]  dec_off;
  logic [7:0]  low_off;
  logic [7:0]  up_off;

  // The stage takes a new item whenever its register is empty or drains this cycle.
  assign in_ch.ready = !valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_code;
  assign dec_off     = c - CH_0;
  assign low_off     = c - CH_LA + 8'd10;
  assign up_off      = c - CH_UA + 8'd10;

  // Classify the incoming character.
  always_comb begin
    class_nxt.is_nul   = (c == CH_NUL);
    class_nxt.is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    class_nxt.is_star  = (c == CH_STAR);
    class_nxt.is_dot   = (c == CH_DOT);
    class_nxt.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    class_nxt.is_minus = (c == CH_MINUS);
    class_nxt.is_x     = (c == CH_LX) || (c == CH_UX);
    if ((c >= CH_0) && (c <= CH_9)) begin
      class_nxt.digit = dec_off[4:0];
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      class_nxt.digit = low_off[4:0];
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      class_nxt.digit = up_off[4:0];
    end else begin
      class_nxt.digit = DIGIT_NONE;
    end
  end

  // Valid flag of the classification register.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      class_r <= class_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_class = class_r;

endmodule

`default_nettype wire

@@ sv/dqap_queue.sv @@
// Short queue of classified characters between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dqap_queue
  import dqap_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  input  char_class_t wr_class,
  output logic        wr_ready,
  output logic        rd_valid,
  output char_class_t rd_class,
  input  logic        rd_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  char_class_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count_r != FULL);
  assign rd_valid = (count_r != '0);
  assign rd_class = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_class;
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("queue fill count above depth");

endmodule

`default_nettype wire

@@ sv/dqap_back.sv @@
// Back stage: runs the address scanner and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module dqap_back
  import dqap_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  char_class_t   q_class,
  output logic          q_ready,
  dqap_result_if.source out_res
);

  typedef enum logic [9:0] {
    PH_LEAD   = 10'b00_0000_0001,
    PH_START  = 10'b00_0000_0010,
    PH_WS     = 10'b00_0000_0100,
    PH_SIGN   = 10'b00_0000_1000,
    PH_ZERO   = 10'b00_0001_0000,
    PH_HEXPFX = 10'b00_0010_0000,
    PH_NUM    = 10'b00_0100_0000,
    PH_TRAIL  = 10'b00_1000_0000,
    PH_STAR   = 10'b01_0000_0000,
    PH_DONE   = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  localparam logic [1:0]  LAST_PART = 2'd3;
  localparam logic [8:0]  SAT_VALUE = 9'd256;
  localparam logic [12:0] SAT_WIDE  = 13'd256;

  phase_t      phase_r,  phase_nxt;
  base_t       base_r,   base_nxt;
  logic [1:0]  idx_r,    idx_nxt;
  logic [8:0]  value_r,  value_nxt;
  logic        neg_r,    neg_nxt;
  logic [23:0] addr_r,   addr_nxt;
  logic        failed_r, failed_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r,    out_ok_nxt;
  logic [31:0] out_addr_r,  out_addr_nxt;

  logic        consume;
  logic        do_begin;
  logic        do_end;
  logic        in_radix;
  logic [12:0] wide_v;
  logic [12:0] scaled_v;
  logic        part_bad;
  logic        result_ok;
  char_class_t cc;

  assign cc      = q_class;
  // A terminator needs room in the result register; other characters always flow.
  assign q_ready = !cc.is_nul || !out_valid_r || out_res.ready;
  assign consume = q_valid && q_ready;

  // Multiply-accumulate of the current part by its radix.
  always_comb begin
    case (base_r)
      BASE_OCT: begin
        in_radix = (cc.digit < 5'd8);
        scaled_v = {1'b0, value_r, 3'b000};
      end
      BASE_HEX: begin
        in_radix = (cc.digit < 5'd16);
        scaled_v = {value_r, 4'b0000};
      end
      default: begin
        in_radix = (cc.digit < 5'd10);
        scaled_v = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0};
      end
    endcase
    wide_v = scaled_v + {8'd0, cc.digit};
  end

  assign part_bad = (value_r > 9'd255) || (neg_r && (value_r != 9'd0));

  // Scanner next state for one character.
  always_comb begin
    phase_nxt  = phase_r;
    base_nxt   = base_r;
    idx_nxt    = idx_r;
    value_nxt  = value_r;
    neg_nxt    = neg_r;
    addr_nxt   = addr_r;
    failed_nxt = failed_r;
    do_begin   = 1'b0;
    do_end     = 1'b0;

    if (!failed_r) begin
      unique case (phase_r) inside
        PH_LEAD, PH_START, PH_WS: begin
          if (cc.is_ws) begin
            if (phase_r == PH_START) begin
              phase_nxt = PH_WS;
            end
          end else if (cc.is_star && (phase_r == PH_LEAD)) begin
            phase_nxt = PH_STAR;
          end else if (cc.is_sign) begin
            neg_nxt   = cc.is_minus;
            phase_nxt = PH_SIGN;
          end else if (cc.digit < 5'd10) begin
            do_begin = 1'b1;
          end else if (phase_r == PH_WS) begin
            if (cc.is_nul && (idx_r == LAST_PART)) begin
              phase_nxt = PH_DONE;
            end else begin
              failed_nxt = 1'b1;
            end
          end else begin
            do_end = 1'b1;
          end
        end
        PH_SIGN: begin
          if (cc.digit < 5'd10) begin
            do_begin = 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_ZERO: begin
          if (cc.is_x) begin
            phase_nxt = PH_HEXPFX;
          end else if (cc.digit < 5'd8) begin
            base_nxt  = BASE_OCT;
            value_nxt = {5'd0, cc.digit[3:0]};
            phase_nxt = PH_NUM;
          end else begin
            do_end = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (cc.digit < 5'd16) begin
            base_nxt  = BASE_HEX;
            value_nxt = {5'd0, cc.digit[3:0]};
            phase_nxt = PH_NUM;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_NUM: begin
          if (in_radix) begin
            value_nxt = (wide_v > SAT_WIDE) ? SAT_VALUE : wide_v[8:0];
          end else begin
            do_end = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (cc.is_nul) begin
            phase_nxt = PH_DONE;
          end else if (!cc.is_ws) begin
            failed_nxt = 1'b1;
          end
        end
        PH_STAR: begin
          // Everything after the wildcard is ignored.
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end

    // First digit of a part: a zero may open an octal or hex number.
    if (do_begin) begin
      if (cc.digit == 5'd0) begin
        value_nxt = 9'd0;
        phase_nxt = PH_ZERO;
      end else begin
        value_nxt = {5'd0, cc.digit[3:0]};
        base_nxt  = BASE_DEC;
        phase_nxt = PH_NUM;
      end
    end

    // End of a number: range check, then a dot, trailing space or the terminator.
    if (do_end) begin
      if (part_bad) begin
        failed_nxt = 1'b1;
      end else if (cc.is_dot && (idx_r != LAST_PART)) begin
        addr_nxt  = {addr_r[15:0], value_r[7:0]};
        idx_nxt   = idx_r + 2'd1;
        value_nxt = 9'd0;
        neg_nxt   = 1'b0;
        base_nxt  = BASE_DEC;
        phase_nxt = PH_START;
      end else if ((idx_r == LAST_PART) && cc.is_ws) begin
        phase_nxt = PH_TRAIL;
      end else if ((idx_r == LAST_PART) && cc.is_nul) begin
        phase_nxt = PH_DONE;
      end else begin
        failed_nxt = 1'b1;
      end
    end
  end

  assign result_ok = !failed_nxt && ((phase_nxt == PH_DONE) || (phase_nxt == PH_STAR));

  // Result register: loaded on a terminator, emptied when the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (consume && cc.is_nul) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = result_ok;
      out_addr_nxt  = (result_ok && (phase_nxt == PH_DONE)) ?
                      {addr_nxt, value_nxt[7:0]} : 32'd0;
    end
  end

  // Scanner state: advances per character and returns to reset after each string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      base_r   <= BASE_DEC;
      idx_r    <= 2'd0;
      value_r  <= 9'd0;
      neg_r    <= 1'b0;
      addr_r   <= 24'd0;
      failed_r <= 1'b0;
    end else if (consume) begin
      if (cc.is_nul) begin
        phase_r  <= PH_LEAD;
        base_r   <= BASE_DEC;
        idx_r    <= 2'd0;
        value_r  <= 9'd0;
        neg_r    <= 1'b0;
        addr_r   <= 24'd0;
        failed_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        base_r   <= base_nxt;
        idx_r    <= idx_nxt;
        value_r  <= value_nxt;
        neg_r    <= neg_nxt;
        addr_r   <= addr_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.ok      = out_ok_r;
  assign out_res.address = out_addr_r;

  // A rejected string always reports address zero.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_addr_r == 32'd0))
    else $error("rejected item carries a nonzero address");

  // The part value saturates and never passes 256.
  a_value_sat: assert property (@(posedge clk) disable iff (!rst_n)
    value_r <= SAT_VALUE)
    else $error("part value above saturation limit");

  // After a terminator the scanner is back in its initial state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && cc.is_nul) |=> ((phase_r == PH_LEAD) && (idx_r == 2'd0) && !failed_r))
    else $error("scanner did not restart after a terminator");

  // A terminator is only taken when the result register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && cc.is_nul) |-> (!out_valid_r || out_res.ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

@@ sv/dotted_quad_address_parser.sv @@
// Top level of the streaming dotted-quad IPv4 address parser.
// Throughput: one character per cycle unless back-pressure stalls the flow, set by the single
// scanner update per character. A terminating zero goes through the classification register
// and the queue, then the scanner loads its result into the result register.
// The result register lets the next string's characters enter while a result waits.
// Reset is synchronous and active low; it empties the queue and result register and
// returns the scanner to its leading-whitespace state. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dotted_quad_address_parser
  import dqap_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  dqap_char_if.sink     in_ch,
  dqap_result_if.source out_res
);

  logic        push_valid;
  logic        push_ready;
  char_class_t push_class;
  logic        q_valid;
  logic        q_ready;
  char_class_t q_class;

  // Front: accept and classify characters.
  dqap_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_class (push_class),
    .push_ready (push_ready)
  );

  // Decoupling queue between front and back.
  dqap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_class (push_class),
    .wr_ready (push_ready),
    .rd_valid (q_valid),
    .rd_class (q_class),
    .rd_ready (q_ready)
  );

  // Back: scanner and result register.
  dqap_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_class (q_class),
    .q_ready (q_ready),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the streaming dotted-quad IPv4 address parser.
`timescale 1ns / 1ps

module tb
  import dqap_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 1540;
  localparam int DRAIN_CYCLES = 10;

  // Character codes the parser treats specially.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";

  typedef enum logic [3:0] {
    ST_LEAD_WS, ST_PART_START, ST_PART_WS, ST_SIGN, ST_ZERO,
    ST_HEX_PREFIX, ST_DIGITS, ST_TRAIL_WS, ST_WILDCARD, ST_COMPLETE
  } scan_state_t;

  typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } addr_result_t;

  typedef struct {
    string       text;
    bit          pinned;
    logic        ok;
    logic [31:0] address;
  } vector_t;

  logic clk;
  logic rst_n;
  dqap_char_if   char_if ();
  dqap_result_if res_if ();

  dotted_quad_address_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_if),
    .out_res(res_if)
  );

  // Scanner state of the address predictor.
  scan_state_t scan_state;
  radix_t      radix;
  logic [1:0]  part_count;
  logic [8:0]  part_val;
  logic        part_neg;
  logic [23:0] addr_prefix;
  logic        parse_failed;

  addr_result_t expected_results[$];
  logic [7:0]   char_buf[$];
  bit           gaps_on;
  bit           pin_result;
  addr_result_t pinned_result;
  int           chars_sent;
  int           cycle_count;
  int           mismatch_count;

  // Directed strings; rows marked pinned carry a hand-written result.
  vector_t directed_vectors [22] = '{
    '{"",                          1'b1, 1'b0, 32'h0000_0000},
    '{"*",                         1'b1, 1'b1, 32'h0000_0000},
    '{"255.255.255.255",           1'b1, 1'b1, 32'hFFFF_FFFF},
    '{"0.0.0.0",                   1'b1, 1'b1, 32'h0000_0000},
    '{"256.1.1.1",                 1'b1, 1'b0, 32'h0000_0000},
    '{"-1.2.3.4",                  1'b1, 1'b0, 32'h0000_0000},
    '{"1.2.3.4.5",                 1'b1, 1'b0, 32'h0000_0000},
    '{"0x.1.2.3",                  1'b1, 1'b0, 32'h0000_0000},
    '{"08.1.2.3",                  1'b1, 1'b0, 32'h0000_0000},
    '{"\t *:x.y",                  1'b0, 1'b0, 32'h0000_0000},
    '{"0x7f.0377.+9. 4",           1'b0, 1'b0, 32'h0000_0000},
    '{"0XFF.0xA.012.-0",           1'b0, 1'b0, 32'h0000_0000},
    '{"1..2.3",                    1'b0, 1'b0, 32'h0000_0000},
    '{" 10.20.30.40 \t\n",         1'b0, 1'b0, 32'h0000_0000},
    '{"1.2.3. ",                   1'b0, 1'b0, 32'h0000_0000},
    '{"1. .2.3",                   1'b0, 1'b0, 32'h0000_0000},
    '{"+.1.2.3",                   1'b0, 1'b0, 32'h0000_0000},
    '{"1.2.3.4 x",                 1'b0, 1'b0, 32'h0000_0000},
    '{"1.2.3",                     1'b0, 1'b0, 32'h0000_0000},
    '{"1.2.3.4x",                  1'b0, 1'b0, 32'h0000_0000},
    '{"\013\014\015192.168.1.1",   1'b0, 1'b0, 32'h0000_0000},
    '{".1.2.3",                    1'b0, 1'b0, 32'h0000_0000}
  };

  string bad_tokens [10] = '{"0x", "08", "+", "-", " ", "0x1g", "-5", "1 2", "09", "*"};

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic void clear_scanner();
    scan_state   = ST_LEAD_WS;
    radix        = RADIX_DEC;
    part_count   = 2'd0;
    part_val     = 9'd0;
    part_neg     = 1'b0;
    addr_prefix  = 24'd0;
    parse_failed = 1'b0;
  endfunction

  // A delimiter ends the current part: store it, or move to the tail, or reject.
  function automatic void close_part(input logic [7:0] c);
    if (part_val > 9'd255 || (part_neg && part_val != 9'd0)) begin
      parse_failed = 1'b1;
    end else if (c == CH_DOT && part_count < 2'd3) begin
      addr_prefix = {addr_prefix[15:0], part_val[7:0]};
      part_count  = part_count + 2'd1;
      part_val    = 9'd0;
      part_neg    = 1'b0;
      radix       = RADIX_DEC;
      scan_state  = ST_PART_START;
    end else if (part_count == 2'd3 && is_space(c)) begin
      scan_state = ST_TRAIL_WS;
    end else if (part_count == 2'd3 && c == CH_NUL) begin
      scan_state = ST_COMPLETE;
    end else begin
      parse_failed = 1'b1;
    end
  endfunction

  function automatic void start_number(input logic [7:0] c);
    if (c == CH_0) begin
      part_val   = 9'd0;
      scan_state = ST_ZERO;
    end else begin
      part_val   = 9'(c - CH_0);
      radix      = RADIX_DEC;
      scan_state = ST_DIGITS;
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic [4:0] d;
    int         r;
    int         v;
    d = digit_of(c);
    case (scan_state)
      ST_LEAD_WS, ST_PART_START, ST_PART_WS: begin
        if (is_space(c)) begin
          if (scan_state == ST_PART_START) scan_state = ST_PART_WS;
        end else if (c == CH_STAR && scan_state == ST_LEAD_WS) begin
          scan_state = ST_WILDCARD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          part_neg   = (c == CH_MINUS);
          scan_state = ST_SIGN;
        end else if (d < 5'd10) begin
          start_number(c);
        end else if (scan_state == ST_PART_WS) begin
          if (c == CH_NUL && part_count == 2'd3) scan_state = ST_COMPLETE;
          else parse_failed = 1'b1;
        end else begin
          close_part(c);
        end
      end
      ST_SIGN: begin
        if (d < 5'd10) start_number(c);
        else parse_failed = 1'b1;
      end
      ST_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          scan_state = ST_HEX_PREFIX;
        end else if (d < 5'd8) begin
          radix      = RADIX_OCT;
          part_val   = 9'(d);
          scan_state = ST_DIGITS;
        end else begin
          close_part(c);
        end
      end
      ST_HEX_PREFIX: begin
        if (d < 5'd16) begin
          radix      = RADIX_HEX;
          part_val   = 9'(d);
          scan_state = ST_DIGITS;
        end else begin
          parse_failed = 1'b1;
        end
      end
      ST_DIGITS: begin
        r = (radix == RADIX_OCT) ? 8 : (radix == RADIX_HEX) ? 16 : 10;
        if (int'(d) < r) begin
          // Saturate so that any overflow stays above 255.
          v = int'(part_val) * r + int'(d);
          part_val = (v > 256) ? 9'd256 : 9'(v);
        end else begin
          close_part(c);
        end
      end
      ST_TRAIL_WS: begin
        if (c == CH_NUL) scan_state = ST_COMPLETE;
        else if (!is_space(c)) parse_failed = 1'b1;
      end
      ST_WILDCARD: ;
      default: parse_failed = 1'b1;
    endcase
  endfunction

  // Advances the predictor by one character; returns 1 when a result is due.
  function automatic bit predict_address(input logic [7:0] c, output addr_result_t res);
    res = '0;
    if (!parse_failed) scan_char(c);
    if (c != CH_NUL) return 1'b0;
    if (!parse_failed && scan_state == ST_COMPLETE) begin
      res.ok      = 1'b1;
      res.address = {addr_prefix, part_val[7:0]};
    end else if (!parse_failed && scan_state == ST_WILDCARD) begin
      res.ok = 1'b1;
    end
    clear_scanner();
    return 1'b1;
  endfunction

  // Offers one character and waits for it to be taken.
  task automatic send_char(input logic [7:0] c);
    addr_result_t res;
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      @(negedge clk);
      char_if.valid <= 1'b0;
    end
    @(negedge clk);
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    chars_sent++;
    if (predict_address(c, res)) begin
      if (pin_result) res = pinned_result;
      expected_results.push_back(res);
    end
  endtask

  task automatic send_buffer();
    foreach (char_buf[i]) send_char(char_buf[i]);
    send_char(CH_NUL);
  endtask

  // Holds the sender off until every pending result has been received.
  task automatic drain_results();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
  endfunction

  function automatic void put_space();
    int k;
    k = $urandom_range(0, 5);
    char_buf.push_back((k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1));
  endfunction

  // One address part in a random radix and format.
  function automatic void put_part();
    int    v;
    int    fmt;
    bit    neg;
    string digits;
    int    pick [6] = '{0, 1, 127, 128, 255, 256};
    neg = 1'b0;
    if ($urandom_range(0, 99) < 5) return;
    if ($urandom_range(0, 9) == 0) put_space();
    if ($urandom_range(0, 99) < 12) begin
      neg = 1'($urandom_range(0, 1));
      char_buf.push_back(neg ? CH_MINUS : CH_PLUS);
    end
    case ($urandom_range(0, 9))
      8:       v = $urandom_range(256, 1023);
      9:       v = pick[$urandom_range(0, 5)];
      default: v = $urandom_range(0, 255);
    endcase
    if (neg && $urandom_range(0, 1)) v = 0;
    fmt = $urandom_range(0, 3);
    case (fmt)
      0: put_text($sformatf("%0d", v));
      1: put_text($sformatf("0%0o", v));
      default: begin
        digits = $sformatf("%0h", v);
        if (fmt == 3) digits = digits.toupper();
        put_text($urandom_range(0, 1) ? "0x" : "0X");
        put_text(digits);
      end
    endcase
  endfunction

  // Builds one random string: mostly addresses, some broken, wildcard or noise.
  function automatic void build_random_string();
    int kind;
    int parts;
    int bad;
    int idx;
    kind = $urandom_range(0, 99);
    char_buf.delete();
    if (kind < 70) begin
      if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) put_space();
      for (int p = 0; p < 4; p++) begin
        put_part();
        if (p < 3) char_buf.push_back(CH_DOT);
      end
      if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 3)) put_space();
      // Occasionally damage an otherwise good address.
      if ($urandom_range(0, 99) < 25) begin
        repeat ($urandom_range(1, 2)) begin
          if (char_buf.size() == 0) begin
            char_buf.push_back(8'($urandom_range(1, 255)));
          end else begin
            idx = $urandom_range(0, char_buf.size() - 1);
            case ($urandom_range(0, 3))
              0: char_buf[idx] = 8'($urandom_range(1, 255));
              1: char_buf.delete(idx);
              2: char_buf.insert(idx, 8'($urandom_range(1, 255)));
              default: begin
                char_buf.push_back(CH_DOT);
                put_part();
              end
            endcase
          end
        end
      end
    end else if (kind < 78) begin
      repeat ($urandom_range(0, 2)) put_space();
      char_buf.push_back(CH_STAR);
      repeat ($urandom_range(0, 6)) char_buf.push_back(8'($urandom_range(1, 255)));
    end else if (kind < 88) begin
      repeat ($urandom_range(0, 12)) char_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      parts = $urandom_range(3, 5);
      bad   = $urandom_range(0, 1) ? $urandom_range(0, parts - 1) : -1;
      for (int p = 0; p < parts; p++) begin
        if (p == bad) put_text(bad_tokens[$urandom_range(0, 9)]);
        else put_part();
        if (p < parts - 1) char_buf.push_back(CH_DOT);
      end
    end
  endfunction

  // Result side: random back-pressure.
  always @(negedge clk) begin
    res_if.ready <= !(gaps_on && ($urandom_range(0, 99) < 29));
  end

  // Result checker against the oldest expected address.
  always @(posedge clk) begin
    addr_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual ok=%0b address=%08h", $time,
                 res_if.ok, res_if.address);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (res_if.ok !== exp_res.ok) begin
          $display("%0t: ok mismatch: expected %0b, actual %0b", $time, exp_res.ok,
                   res_if.ok);
          mismatch_count++;
        end
        if (res_if.address !== exp_res.address) begin
          $display("%0t: address mismatch: expected %08h, actual %08h", $time,
                   exp_res.address, res_if.address);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    int  random_start;
    bit  paused;
    cycle_count       = 0;
    mismatch_count    = 0;
    chars_sent        = 0;
    gaps_on           = 1'b1;
    pin_result        = 1'b0;
    pinned_result     = '0;
    paused            = 1'b0;
    rst_n             = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = 8'h00;
    res_if.ready      = 1'b0;
    clear_scanner();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings.
    foreach (directed_vectors[i]) begin
      char_buf.delete();
      put_text(directed_vectors[i].text);
      pin_result            = directed_vectors[i].pinned;
      pinned_result.ok      = directed_vectors[i].ok;
      pinned_result.address = directed_vectors[i].address;
      send_buffer();
    end
    pin_result = 1'b0;
    drain_results();

    // Random strings, with one stretch of no idling and one full drain.
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      gaps_on = !((chars_sent - random_start) >= 700 && (chars_sent - random_start) < 1000);
      if (!paused && (chars_sent - random_start) >= 1200) begin
        paused = 1'b1;
        drain_results();
      end
      build_random_string();
      send_buffer();
    end

    // Wait out the remaining results and the pipeline.
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
